/* hdl/mlpd_pkg.sv */
`default_nettype none

package mlpd_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PROTO = 2'd1,
    ST_CAP   = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  localparam logic [2:0] CFG_CHECK_PREAMBLE = 3'd0;
  localparam logic [2:0] CFG_MAX_PAYLOAD    = 3'd1;
  localparam logic [2:0] CFG_KIND_CODE_A    = 3'd2;
  localparam logic [2:0] CFG_KIND_CODE_B    = 3'd3;
  localparam logic [2:0] CFG_KIND_CODE_C    = 3'd4;

  localparam logic [2:0]  PREAMBLE_LENGTH   = 3'd7;
  localparam logic [3:0]  HEADER_LENGTH     = 4'd8;
  localparam logic [3:0]  HEADER_LAST       = 4'd7;
  localparam logic [24:0] MAX_PAYLOAD_BYTES = 25'd65536;
  localparam logic [16:0] MAX_PAYLOAD_RESET = 17'd65536;

  typedef struct packed {
    logic        byte_taken;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] frame_kind;
    logic        frame_end;
    status_t     status;
  } result_t;

  function automatic logic [7:0] preamble_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'h46;
      3'd1:    val = 8'h52;
      3'd2:    val = 8'h50;
      3'd3:    val = 8'h00;
      3'd4:    val = 8'h02;
      3'd5:    val = 8'h0D;
      3'd6:    val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

/* hdl/magic_and_length_prefixed_deframer.sv */
// The result of an accepted request is registered in out_r, or in skid_r while a result waits.
// Throughput: one request per cycle while in_ready is high; each byte needs only counters and compares.
// An output register plus a skid register let one more request enter while a result waits.
// Reset (rst_n low at a clock edge) loads the register defaults, clears all counters,
// the stored kind and the sticky error, and empties the output stage.
`default_nettype none

module magic_and_length_prefixed_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_byte_taken,
  output logic             out_payload_valid,
  output logic [7:0]       out_payload_byte,
  output logic [15:0]      out_frame_kind,
  output logic             out_frame_end,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  logic                check_preamble_r;
  logic [16:0]         max_payload_r;
  logic [15:0]         kind_code_a_r;
  logic [15:0]         kind_code_b_r;
  logic [15:0]         kind_code_c_r;

  logic [2:0]          preamble_count_r, preamble_count_nxt;
  logic [3:0]          header_count_r, header_count_nxt;
  logic [7:0]          header_r [0:6];
  logic [15:0]         current_kind_r, current_kind_nxt;
  logic [16:0]         payload_length_r, payload_length_nxt;
  logic [16:0]         payload_count_r, payload_count_nxt;
  mlpd_pkg::status_t   sticky_r, sticky_nxt;

  logic                header_we;
  mlpd_pkg::result_t   res;
  mlpd_pkg::result_t   out_r;
  mlpd_pkg::result_t   skid_r;
  logic                out_valid_r;
  logic                skid_valid_r;
  logic                in_accept;

  assign in_ready  = !skid_valid_r;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [15:0] kind;
    logic [31:0] len;
    logic [16:0] cap;
    logic        kind_ok;

    preamble_count_nxt = preamble_count_r;
    header_count_nxt   = header_count_r;
    current_kind_nxt   = current_kind_r;
    payload_length_nxt = payload_length_r;
    payload_count_nxt  = payload_count_r;
    sticky_nxt         = sticky_r;
    header_we          = 1'b0;
    res                = '0;
    res.status         = mlpd_pkg::ST_OK;

    kind    = {header_r[0], header_r[1]};
    len     = {header_r[4], header_r[5], header_r[6], in_stream_byte};
    cap     = ({8'd0, max_payload_r} < mlpd_pkg::MAX_PAYLOAD_BYTES) ? max_payload_r
                                                                  : mlpd_pkg::MAX_PAYLOAD_BYTES[16:0];
    kind_ok = (kind == kind_code_a_r) || (kind == kind_code_b_r) || (kind == kind_code_c_r);

    if (in_op) begin
      if (sticky_r != mlpd_pkg::ST_OK) begin
        res.status = sticky_r;
      end else if ((check_preamble_r && preamble_count_r != mlpd_pkg::PREAMBLE_LENGTH)
                   || header_count_r != 4'd0) begin
        res.status = mlpd_pkg::ST_TRUNC;
      end
    end else if (sticky_r != mlpd_pkg::ST_OK) begin
      res.status = sticky_r;
    end else begin
      res.byte_taken = 1'b1;
      if (check_preamble_r && preamble_count_r != mlpd_pkg::PREAMBLE_LENGTH) begin
        if (in_stream_byte != mlpd_pkg::preamble_byte(preamble_count_r)) begin
          sticky_nxt = mlpd_pkg::ST_PROTO;
          res.status = mlpd_pkg::ST_PROTO;
        end
        preamble_count_nxt = preamble_count_r + 3'd1;
      end else if (header_count_r != mlpd_pkg::HEADER_LENGTH) begin
        header_count_nxt = header_count_r + 4'd1;
        if (header_count_r != mlpd_pkg::HEADER_LAST) begin
          header_we = 1'b1;
        end else if (!kind_ok || header_r[2] != 8'd0 || header_r[3] != 8'd0) begin
          sticky_nxt = mlpd_pkg::ST_PROTO;
          res.status = mlpd_pkg::ST_PROTO;
        end else if (len > {15'd0, cap}) begin
          current_kind_nxt = kind;
          sticky_nxt       = mlpd_pkg::ST_CAP;
          res.status       = mlpd_pkg::ST_CAP;
        end else begin
          current_kind_nxt   = kind;
          payload_length_nxt = len[16:0];
          payload_count_nxt  = 17'd0;
          if (len == 32'd0) begin
            res.frame_kind   = kind;
            res.frame_end    = 1'b1;
            header_count_nxt = 4'd0;
          end
        end
      end else begin
        res.payload_valid = 1'b1;
        res.payload_byte  = in_stream_byte;
        res.frame_kind    = current_kind_r;
        payload_count_nxt = payload_count_r + 17'd1;
        if (payload_count_nxt >= payload_length_r) begin
          res.frame_end      = 1'b1;
          header_count_nxt   = 4'd0;
          payload_length_nxt = 17'd0;
          payload_count_nxt  = 17'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_preamble_r <= 1'b1;
      max_payload_r    <= mlpd_pkg::MAX_PAYLOAD_RESET;
      kind_code_a_r    <= 16'd0;
      kind_code_b_r    <= 16'd0;
      kind_code_c_r    <= 16'd0;
      preamble_count_r <= 3'd0;
      header_count_r   <= 4'd0;
      current_kind_r   <= 16'd0;
      payload_length_r <= 17'd0;
      payload_count_r  <= 17'd0;
      sticky_r         <= mlpd_pkg::ST_OK;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mlpd_pkg::CFG_CHECK_PREAMBLE: check_preamble_r <= cfg_data[0];
          mlpd_pkg::CFG_MAX_PAYLOAD:    max_payload_r    <= cfg_data;
          mlpd_pkg::CFG_KIND_CODE_A:    kind_code_a_r    <= cfg_data[15:0];
          mlpd_pkg::CFG_KIND_CODE_B:    kind_code_b_r    <= cfg_data[15:0];
          mlpd_pkg::CFG_KIND_CODE_C:    kind_code_c_r    <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        preamble_count_r <= preamble_count_nxt;
        header_count_r   <= header_count_nxt;
        current_kind_r   <= current_kind_nxt;
        payload_length_r <= payload_length_nxt;
        payload_count_r  <= payload_count_nxt;
        sticky_r         <= sticky_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && header_we) begin
      header_r[header_count_r[2:0]] <= in_stream_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_ready) begin
      if (in_accept) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_ready) begin
      if (in_accept) begin
        skid_r <= res;
      end
    end else if (skid_valid_r) begin
      out_r <= skid_r;
    end else if (in_accept) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte_taken    = out_r.byte_taken;
  assign out_payload_valid = out_r.payload_valid;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_frame_kind    = out_r.frame_kind;
  assign out_frame_end     = out_r.frame_end;
  assign out_status        = out_r.status;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  a_header_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    header_count_r <= mlpd_pkg::HEADER_LENGTH)
    else $error("header count beyond header length");

  a_payload_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (header_count_r == mlpd_pkg::HEADER_LENGTH && sticky_r == mlpd_pkg::ST_OK)
    |-> (payload_count_r < payload_length_r))
    else $error("payload phase with count not below length");

  a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (sticky_r != mlpd_pkg::ST_OK) |=> $stable(sticky_r) && $stable(header_count_r))
    else $error("state changed after a sticky error");

endmodule

`default_nettype wire

/* dv/magic_and_length_prefixed_deframer_test.sv */
`timescale 1ns / 100ps

module magic_and_length_prefixed_deframer_test;
  import mlpd_pkg::*;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_FINISH = 1'b1;
  localparam logic [55:0] PREAMBLE_BYTES = 56'h46_52_50_00_02_0D_0A;
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_REQUESTS = 1350;

  typedef enum {
    FAULT_PREAMBLE,
    FAULT_KIND,
    FAULT_PAD,
    FAULT_LENGTH,
    FAULT_CLIPPED
  } fault_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [16:0] data;
    logic        op;
    logic [7:0]  b;
    bit          typed;
    result_t     want;
  } row_t;

  typedef struct {
    logic [2:0]  idx;
    logic [16:0] data;
  } reg_wr_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [7:0]  in_stream_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_byte_taken;
  logic        out_payload_valid;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_frame_kind;
  logic        out_frame_end;
  logic [1:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  // Shadow copy of the registers and of the deframer state.
  logic        chk_pre;
  logic [16:0] max_reg;
  logic [15:0] kind_a;
  logic [15:0] kind_b;
  logic [15:0] kind_c;
  logic [2:0]  pre_seen;
  logic [3:0]  hdr_cnt;
  logic [7:0]  hdr_buf [8];
  logic [15:0] frm_kind;
  logic [16:0] frm_len;
  logic [16:0] frm_cnt;
  status_t     err_code;

  result_t pending_results[$];
  reg_wr_t reg_writes[$];
  row_t    steps[$];

  int     n_req;
  int     n_res;
  int     n_frames;
  int     n_cfg;
  int     n_fail;
  int     n_table;
  int     idle_cycles;
  int     tx_calm;
  int     rx_calm;
  bit     long_stall_done;
  fault_t fault;

  magic_and_length_prefixed_deframer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_stream_byte    (in_stream_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte_taken    (out_byte_taken),
    .out_payload_valid (out_payload_valid),
    .out_payload_byte  (out_payload_byte),
    .out_frame_kind    (out_frame_kind),
    .out_frame_end     (out_frame_end),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [7:0] preamble_at(logic [2:0] i);
    return PREAMBLE_BYTES[8 * (6 - i) +: 8];
  endfunction

  function automatic logic [16:0] eff_cap();
    return (max_reg < MAX_PAYLOAD_BYTES) ? max_reg : 17'(MAX_PAYLOAD_BYTES);
  endfunction

  function automatic result_t deframe_byte(logic op, logic [7:0] b);
    result_t     r;
    logic [15:0] k;
    logic [31:0] len;
    r = '0;
    r.status = ST_OK;
    if (op == OP_FINISH) begin
      if (err_code != ST_OK) begin
        r.status = err_code;
      end else if ((chk_pre && pre_seen != PREAMBLE_LENGTH) || hdr_cnt != 0) begin
        r.status = ST_TRUNC;
      end
    end else if (err_code != ST_OK) begin
      r.status = err_code;
    end else begin
      r.byte_taken = 1'b1;
      if (chk_pre && pre_seen < PREAMBLE_LENGTH) begin
        if (b != preamble_at(pre_seen)) begin
          err_code = ST_PROTO;
          r.status = ST_PROTO;
        end
        pre_seen++;
      end else if (hdr_cnt < HEADER_LENGTH) begin
        hdr_buf[hdr_cnt[2:0]] = b;
        hdr_cnt++;
        if (hdr_cnt == HEADER_LENGTH) begin
          k = {hdr_buf[0], hdr_buf[1]};
          len = {hdr_buf[4], hdr_buf[5], hdr_buf[6], hdr_buf[7]};
          if (!(k == kind_a || k == kind_b || k == kind_c) ||
              hdr_buf[2] != 8'h00 || hdr_buf[3] != 8'h00) begin
            err_code = ST_PROTO;
            r.status = ST_PROTO;
          end else if (len > eff_cap()) begin
            frm_kind = k;
            err_code = ST_CAP;
            r.status = ST_CAP;
          end else begin
            frm_kind = k;
            frm_len = len[16:0];
            frm_cnt = '0;
            if (len == 0) begin
              r.frame_kind = k;
              r.frame_end = 1'b1;
              hdr_cnt = '0;
              n_frames++;
            end
          end
        end
      end else begin
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        r.frame_kind = frm_kind;
        frm_cnt++;
        if (frm_cnt >= frm_len) begin
          r.frame_end = 1'b1;
          hdr_cnt = '0;
          frm_len = '0;
          frm_cnt = '0;
          n_frames++;
        end
      end
    end
    return r;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_len(logic [16:0] cap);
    int          r;
    int unsigned lim;
    r = $urandom_range(0, 99);
    if (r < 55) lim = 4;
    else if (r < 88) lim = 40;
    else if (r < 97) lim = 300;
    else return (cap <= 300) ? cap : $urandom_range(0, 300);
    return $urandom_range(0, (cap < lim) ? cap : lim);
  endfunction

  function automatic logic [15:0] rand_code();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_kind();
    case ($urandom_range(0, 2))
      0: return kind_a;
      1: return kind_b;
      default: return kind_c;
    endcase
  endfunction

  function automatic void add_row(bit is_cfg, logic [2:0] idx, logic [16:0] data, logic op,
                                  logic [7:0] b, bit typed, result_t want);
    row_t row;
    row.is_cfg = is_cfg;
    row.idx = idx;
    row.data = data;
    row.op = op;
    row.b = b;
    row.typed = typed;
    row.want = want;
    steps.push_back(row);
  endfunction

  task automatic send_req(logic op, logic [7:0] b, bit typed = 1'b0, result_t want = '0);
    int      gap;
    result_t p;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    p = deframe_byte(op, b);
    pending_results.push_back(typed ? want : p);
    n_req++;
  endtask

  task automatic send_byte(logic [7:0] b);
    if ($urandom_range(0, 19) == 0) send_req(OP_FINISH, 8'($urandom));
    send_req(OP_FEED, b);
  endtask

  task automatic send_header(logic [15:0] kind, logic [7:0] p2, logic [7:0] p3,
                             logic [31:0] len);
    while (chk_pre && pre_seen < PREAMBLE_LENGTH) send_byte(preamble_at(pre_seen));
    send_byte(kind[15:8]);
    send_byte(kind[7:0]);
    send_byte(p2);
    send_byte(p3);
    send_byte(len[31:24]);
    send_byte(len[23:16]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  task automatic send_frame(logic [15:0] kind, int unsigned len);
    send_header(kind, 8'h00, 8'h00, len);
    repeat (len) send_byte(8'($urandom));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] data);
    reg_wr_t w;
    w.idx = idx;
    w.data = data;
    reg_writes.push_back(w);
  endtask

  // Registers change only with no request in flight.
  task automatic commit_regs();
    reg_wr_t w;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.data;
      do @(posedge clk); while (!cfg_ready);
      case (w.idx)
        CFG_CHECK_PREAMBLE: chk_pre = w.data[0];
        CFG_MAX_PAYLOAD:    max_reg = w.data;
        CFG_KIND_CODE_A:    kind_a = w.data[15:0];
        CFG_KIND_CODE_B:    kind_b = w.data[15:0];
        CFG_KIND_CODE_C:    kind_c = w.data[15:0];
        default: ;
      endcase
      n_cfg++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (n_fail < 100) $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      n_res <= n_res + 1;
      if (pending_results.size() == 0) begin
        if (n_fail < 100) $error("result with no request outstanding");
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        check_field("byte_taken", want.byte_taken, out_byte_taken);
        check_field("payload_valid", want.payload_valid, out_payload_valid);
        check_field("payload_byte", want.payload_byte, out_payload_byte);
        check_field("frame_kind", want.frame_kind, out_frame_kind);
        check_field("frame_end", want.frame_end, out_frame_end);
        check_field("status", want.status, out_status);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side; one long hold-off lets the output stage fill and back up the input.
  initial begin
    int gap;
    out_ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = pick_gap(rx_calm);
      if (!long_stall_done && n_res >= 400) begin
        gap = 300;
        long_stall_done = 1'b1;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int          start;
    int          target;
    int          phase;
    logic [15:0] k;
    logic [7:0]  p2;
    logic [31:0] len;
    logic [16:0] maxp;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_FEED;
    in_stream_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = CFG_CHECK_PREAMBLE;
    cfg_data = '0;
    chk_pre = 1'b1;
    max_reg = MAX_PAYLOAD_RESET;
    kind_a = '0;
    kind_b = '0;
    kind_c = '0;
    pre_seen = '0;
    hdr_cnt = '0;
    frm_kind = '0;
    frm_len = '0;
    frm_cnt = '0;
    err_code = ST_OK;
    n_req = 0;
    n_res = 0;
    n_frames = 0;
    n_cfg = 0;
    n_fail = 0;
    idle_cycles = 0;
    tx_calm = 0;
    rx_calm = 0;
    long_stall_done = 1'b0;
    fault = fault_t'($urandom_range(0, 4));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The first query sees the reset defaults: preamble required and not yet seen.
    add_row(0, 0, 0, OP_FINISH, 8'h00, 1, {1'b0, 1'b0, 8'h00, 16'h0000, 1'b0, ST_TRUNC});
    add_row(1, CFG_CHECK_PREAMBLE, 17'd0, 0, 0, 0, '0);
    add_row(0, 0, 0, OP_FINISH, 8'hFF, 1, {1'b0, 1'b0, 8'h00, 16'h0000, 1'b0, ST_OK});
    repeat (7) add_row(0, 0, 0, OP_FEED, 8'h00, 0, '0);
    add_row(0, 0, 0, OP_FEED, 8'h00, 1, {1'b1, 1'b0, 8'h00, 16'h0000, 1'b1, ST_OK});
    add_row(0, 0, 0, OP_FEED, 8'h00, 0, '0);
    add_row(0, 0, 0, OP_FEED, 8'h00, 0, '0);
    add_row(0, 0, 0, OP_FINISH, 8'h00, 1, {1'b0, 1'b0, 8'h00, 16'h0000, 1'b0, ST_TRUNC});
    // Turning the preamble check on in the middle of a header diverts the next bytes.
    add_row(1, CFG_CHECK_PREAMBLE, 17'd1, 0, 0, 0, '0);
    add_row(0, 0, 0, OP_FEED, 8'h46, 0, '0);
    add_row(0, 0, 0, OP_FEED, 8'h52, 0, '0);
    add_row(0, 0, 0, OP_FEED, 8'h50, 0, '0);
    add_row(1, CFG_CHECK_PREAMBLE, 17'd0, 0, 0, 0, '0);
    repeat (5) add_row(0, 0, 0, OP_FEED, 8'h00, 0, '0);
    add_row(0, 0, 0, OP_FEED, 8'h01, 0, '0);
    add_row(0, 0, 0, OP_FEED, 8'hFF, 1, {1'b1, 1'b1, 8'hFF, 16'h0000, 1'b1, ST_OK});
    add_row(0, 0, 0, OP_FINISH, 8'h00, 0, '0);

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        write_reg(steps[i].idx, steps[i].data);
        commit_regs();
      end else begin
        send_req(steps[i].op, steps[i].b, steps[i].typed, steps[i].want);
      end
    end
    n_table = n_req;

    phase = 0;
    while (n_req < n_table + RANDOM_REQUESTS) begin
      case (phase)
        0: maxp = 17'd1;
        1: maxp = 17'h1FFFF;
        2: maxp = 17'd0;
        3: maxp = MAX_PAYLOAD_RESET;
        default: begin
          case ($urandom_range(0, 4))
            0: maxp = 17'($urandom_range(0, 4));
            1: maxp = 17'($urandom_range(5, 300));
            2: maxp = MAX_PAYLOAD_RESET;
            3: maxp = 17'($urandom_range(0, 17'h1FFFF));
            default: maxp = 17'h1FFFF;
          endcase
        end
      endcase
      write_reg(CFG_CHECK_PREAMBLE,
                (fault == FAULT_PREAMBLE) ? 17'd0 : 17'($urandom_range(0, 1)));
      write_reg(CFG_MAX_PAYLOAD, maxp);
      write_reg(CFG_KIND_CODE_A, (phase == 0) ? 17'h00000 : {1'b0, rand_code()});
      write_reg(CFG_KIND_CODE_B, (phase == 0) ? 17'h0FFFF : {1'b0, rand_code()});
      write_reg(CFG_KIND_CODE_C, {1'b0, rand_code()});
      commit_regs();
      start = n_req;
      target = $urandom_range(100, 250);
      while (n_req - start < target) begin
        send_frame(pick_kind(), pick_len(eff_cap()));
        if ($urandom_range(0, 19) == 0) send_req(OP_FINISH, 8'($urandom));
      end
      phase++;
    end

    // One frame whose length equals the capacity.
    write_reg(CFG_MAX_PAYLOAD, 17'd64);
    commit_regs();
    send_frame(pick_kind(), 64);
    send_req(OP_FINISH, 8'($urandom));

    // The stream ends with one error, which then holds for every later request.
    case (fault)
      FAULT_PREAMBLE: begin
        write_reg(CFG_CHECK_PREAMBLE, 17'd1);
        commit_regs();
        send_byte(preamble_at(pre_seen));
        send_req(OP_FEED, preamble_at(pre_seen) ^ 8'($urandom_range(1, 255)));
      end
      FAULT_KIND: begin
        k = 16'($urandom);
        while (k == kind_a || k == kind_b || k == kind_c) k = 16'($urandom);
        send_header(k, 8'h00, 8'h00, pick_len(eff_cap()));
      end
      FAULT_PAD: begin
        p2 = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        send_header(pick_kind(), p2,
                    (p2 == 8'h00) ? 8'($urandom_range(1, 255)) : 8'($urandom), 0);
      end
      FAULT_LENGTH: begin
        len = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF :
              32'(eff_cap()) + 32'd1 + $urandom_range(0, 1000);
        send_header(pick_kind(), 8'h00, 8'h00, len);
      end
      default: begin
        write_reg(CFG_MAX_PAYLOAD, 17'h1FFFF);
        commit_regs();
        send_header(pick_kind(), 8'h00, 8'h00, 32'd65537);
      end
    endcase
    repeat (8) send_req(1'($urandom), 8'($urandom));

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    $display("run: %0d requests (%0d from the table), %0d results, %0d frames completed",
             n_req, n_table, n_res, n_frames);
    $display("run: %0d register writes, stream closed by a %s error", n_cfg, fault.name());
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/mlpd_pkg.sv
hdl/magic_and_length_prefixed_deframer.sv
dv/magic_and_length_prefixed_deframer_test.sv
